[src/kpt_pkg.sv]
`timescale 1ns / 1ps

package kpt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int ENTRY_W     = 2 * DATA_W;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    // control from the sequencer to the scan unit
    typedef struct packed {
        logic             clear;
        logic             rd_vld;
        logic [IDX_W-1:0] rd_idx;
        logic             fold_new;
    } t_scan_ctrl;

    // status from the scan unit back to the sequencer
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  hit_idx;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] lo;
    } t_scan_stat;

endpackage

[src/kpt_ram.sv]
`timescale 1ns / 1ps

module kpt_ram #(
    parameter int P_WIDTH = 64,
    parameter int P_DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/kpt_scan_unit.sv]
`timescale 1ns / 1ps

module kpt_scan_unit import kpt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_scan_ctrl        i_ctrl,
    input  logic [DATA_W-1:0] i_key,
    input  logic [DATA_W-1:0] i_new_price,
    input  logic [DATA_W-1:0] i_rd_stamp,
    input  logic [DATA_W-1:0] i_rd_price,
    output t_scan_stat        o_stat
);

    logic              r_found, n_found;
    logic [IDX_W-1:0]  r_hit, n_hit;
    logic              r_any, n_any;
    logic [DATA_W-1:0] r_hi, n_hi;
    logic [DATA_W-1:0] r_lo, n_lo;

    logic              is_hit;
    logic              do_fold;
    logic [DATA_W-1:0] cand;

    // shared key compare and min/max compare
    always_comb begin
        is_hit  = i_ctrl.rd_vld && !r_found && (i_rd_stamp == i_key);
        do_fold = i_ctrl.fold_new || (i_ctrl.rd_vld && !is_hit);
        cand    = i_ctrl.fold_new ? i_new_price : i_rd_price;

        n_found = r_found;
        n_hit   = r_hit;
        n_any   = r_any;
        n_hi    = r_hi;
        n_lo    = r_lo;

        if (i_ctrl.clear) begin
            n_found = 1'b0;
            n_any   = 1'b0;
            n_hi    = '0;
            n_lo    = '0;
        end else begin
            if (is_hit) begin
                n_found = 1'b1;
                n_hit   = i_ctrl.rd_idx;
            end
            // the hit entry's old price is left out, its new price is folded later
            if (do_fold) begin
                n_any = 1'b1;
                if (!r_any || cand > r_hi) begin
                    n_hi = cand;
                end
                if (!r_any || cand < r_lo) begin
                    n_lo = cand;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_any   <= 1'b0;
            r_hi    <= '0;
            r_lo    <= '0;
        end else begin
            r_found <= n_found;
            r_any   <= n_any;
            r_hi    <= n_hi;
            r_lo    <= n_lo;
        end
        r_hit <= n_hit;
    end

    assign o_stat.found   = r_found;
    assign o_stat.hit_idx = r_hit;
    assign o_stat.hi      = r_hi;
    assign o_stat.lo      = r_lo;

endmodule

[src/keyed_price_table_min_max_top.sv]
`timescale 1ns / 1ps

// Keyed price table with latest, maximum and minimum tracking. Each item is a
// (stamp, price) update: a stored stamp has its price corrected, a new stamp
// takes the next free slot, and a new stamp on a full table is dropped and
// flagged. Every item gives one result with the price at the highest stamp
// stored, and the largest and smallest stored price. Entries are never removed,
// so the table fills from slot zero and a fill count marks the live entries;
// no clearing pass is needed after reset. The time from acceptance to the next
// possible acceptance grows with the fill count, set by the single read port
// of the table RAM, which is swept one entry per cycle through one shared
// compare unit that searches for the key and folds minimum and maximum in the
// same pass; the registered read needs a drain step for the last entry before
// the sweep is left. The result sits in an output register, so a new item is
// taken while the previous result is still waiting; only if that result is
// still held when the next one is ready does the block wait for the output.

module keyed_price_table_min_max_top import kpt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [DATA_W-1:0] i_stamp,
    input  logic [DATA_W-1:0] i_price_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_latest_price,
    output logic [DATA_W-1:0] o_max_price,
    output logic [DATA_W-1:0] o_min_price,
    output logic              o_dropped
);

    t_state            r_state, n_state;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] r_val;
    logic [CNT_W-1:0]  r_addr;
    logic              r_pend;
    logic [IDX_W-1:0]  r_pend_idx;
    logic [CNT_W-1:0]  r_count;
    logic [DATA_W-1:0] r_newest_stamp;
    logic [DATA_W-1:0] r_newest_price;
    logic              r_drop;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_latest;
    logic [DATA_W-1:0] r_max;
    logic [DATA_W-1:0] r_min;
    logic              r_dropped;

    logic              accept;
    logic              issue;
    logic              drop_now;
    logic              out_free;
    logic              out_load;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_scan_ctrl        scan_ctrl;
    t_scan_stat        scan_stat;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!issue && !r_pend) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        issue              = 1'b0;
        drop_now           = 1'b0;
        ram_we             = 1'b0;
        out_load           = 1'b0;
        scan_ctrl.clear    = accept;
        scan_ctrl.rd_vld   = r_pend;
        scan_ctrl.rd_idx   = r_pend_idx;
        scan_ctrl.fold_new = 1'b0;
        ram_waddr          = scan_stat.found ? scan_stat.hit_idx : r_count[IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
            end
            S_SCAN: begin
                issue = (r_addr != r_count);
            end
            S_WRITE: begin
                drop_now           = !scan_stat.found && (r_count == CNT_W'(TABLE_DEPTH));
                ram_we             = !drop_now;
                scan_ctrl.fold_new = !drop_now;
            end
            S_DONE: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_pend         <= 1'b0;
            r_count        <= '0;
            r_newest_stamp <= '0;
            r_newest_price <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= issue;
            // fill count grows on every new stamp stored
            if (ram_we && !scan_stat.found) begin
                r_count <= r_count + CNT_W'(1);
            end
            // latest price, a tie goes to the later update
            if (ram_we && r_key >= r_newest_stamp) begin
                r_newest_stamp <= r_key;
                r_newest_price <= r_val;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item capture, read address walk and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key  <= i_stamp;
            r_val  <= i_price_in;
            r_addr <= '0;
        end else if (issue) begin
            r_addr <= r_addr + CNT_W'(1);
        end
        r_pend_idx <= r_addr[IDX_W-1:0];
        if (r_state == S_WRITE) begin
            r_drop <= drop_now;
        end
        if (out_load) begin
            r_latest  <= r_newest_price;
            r_max     <= scan_stat.hi;
            r_min     <= scan_stat.lo;
            r_dropped <= r_drop;
        end
    end

    kpt_ram #(
        .P_WIDTH (ENTRY_W),
        .P_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_key, r_val}),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    kpt_scan_unit u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (scan_ctrl),
        .i_key       (r_key),
        .i_new_price (r_val),
        .i_rd_stamp  (ram_rdata[ENTRY_W-1:DATA_W]),
        .i_rd_price  (ram_rdata[DATA_W-1:0]),
        .o_stat      (scan_stat)
    );

    assign o_out_valid    = r_out_valid;
    assign o_latest_price = r_latest;
    assign o_max_price    = r_max;
    assign o_min_price    = r_min;
    assign o_dropped      = r_dropped;

`ifndef SYNTHESIS
    // fill count never passes the table depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // a hit always lies inside the live part of the table
    a_hit_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && scan_stat.found) |-> (CNT_W'(scan_stat.hit_idx) < r_count))
        else $error("key hit outside live entries");

    // a new stamp grows the table by exactly one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && !scan_stat.found) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("fill count did not step on insert");

    // a dropped item only reaches the output with a full table
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_drop) |-> (r_count == CNT_W'(TABLE_DEPTH)))
        else $error("drop flagged on a table with space");
`endif

endmodule

[tb/tb_keyed_price_table_min_max_top.sv]
`timescale 1ns / 1ps

module tb_keyed_price_table_min_max_top;
    import kpt_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 800;
    localparam int N_DIRECTED   = 18;

    // one result item as the block returns it
    typedef struct packed {
        logic [DATA_W-1:0] latest;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] lo;
        logic              dropped;
    } t_quote;

    // directed stimulus row, with a hand-written result where one is obvious
    typedef struct packed {
        logic [DATA_W-1:0] stamp;
        logic [DATA_W-1:0] price;
        logic              fixed;
        t_quote            want;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [N_DIRECTED] = '{
        // first update after reset always becomes the latest
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
          '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}},
        // correction of the only key, equal stamp takes over the latest
        '{32'h0000_0000, 32'h0000_0000, 1'b1,
          '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0}},
        '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1,
          '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0}},
        // correction of an older key leaves the latest alone
        '{32'h0000_0000, 32'h0001_2345, 1'b0, '0},
        '{32'h0000_0001, 32'h0000_0007, 1'b0, '0},
        '{32'h0000_03E8, 32'h0000_01F4, 1'b0, '0},
        '{32'h0000_03E7, 32'hAAAA_AAAA, 1'b0, '0},
        '{32'h0000_03E8, 32'h5555_5555, 1'b0, '0},
        '{32'h8000_0000, 32'h8000_0000, 1'b0, '0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
        '{32'h8000_0000, 32'h0000_0001, 1'b0, '0},
        '{32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
        // tie on the highest stamp goes to the later update
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{32'hFFFF_FFFE, 32'h0000_0003, 1'b0, '0},
        '{32'h0000_0000, 32'h0000_0000, 1'b0, '0}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [DATA_W-1:0] i_stamp;
    logic [DATA_W-1:0] i_price_in;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [DATA_W-1:0] o_latest_price;
    logic [DATA_W-1:0] o_max_price;
    logic [DATA_W-1:0] o_min_price;
    logic              o_dropped;

    // shadow copy of the price table
    logic [DATA_W-1:0] tab_stamp [TABLE_DEPTH];
    logic [DATA_W-1:0] tab_price [TABLE_DEPTH];
    int                fill_count;
    logic [DATA_W-1:0] newest_stamp;
    logic [DATA_W-1:0] newest_price;

    t_quote quote_q [$];
    int     err_count;
    int     items_sent;
    int     quotes_seen;
    int     cycle_count;
    int     stall_left;
    bit     hold_done;

    keyed_price_table_min_max_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_stamp        (i_stamp),
        .i_price_in     (i_price_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_latest_price (o_latest_price),
        .o_max_price    (o_max_price),
        .o_min_price    (o_min_price),
        .o_dropped      (o_dropped)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // apply one update to the shadow table and work out the quote it gives
    function automatic t_quote price_table_update(logic [DATA_W-1:0] stamp,
                                                  logic [DATA_W-1:0] price);
        t_quote res;
        int     hit;
        int     i;
        hit = -1;
        res = '0;
        for (i = 0; i < fill_count; i++) begin
            if (hit < 0 && tab_stamp[i] == stamp) hit = i;
        end
        // slots are never freed, so the live entries are always 0 .. fill_count-1
        if (hit >= 0) begin
            tab_price[hit] = price;
        end else if (fill_count < TABLE_DEPTH) begin
            tab_stamp[fill_count] = stamp;
            tab_price[fill_count] = price;
            fill_count++;
        end else begin
            res.dropped = 1'b1;
        end
        if (!res.dropped && stamp >= newest_stamp) begin
            newest_stamp = stamp;
            newest_price = price;
        end
        res.latest = newest_price;
        for (i = 0; i < fill_count; i++) begin
            if (i == 0 || tab_price[i] > res.hi) res.hi = tab_price[i];
            if (i == 0 || tab_price[i] < res.lo) res.lo = tab_price[i];
        end
        return res;
    endfunction

    // prices lean towards the extremes now and then
    function automatic logic [DATA_W-1:0] rand_price();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return '1;
        if (r < 24) return DATA_W'($urandom_range(0, 15));
        if (r < 32) return '1 - DATA_W'($urandom_range(0, 15));
        return $urandom;
    endfunction

    // stamps that are probably not stored yet, some right next to stored ones
    function automatic logic [DATA_W-1:0] rand_new_stamp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25 && fill_count > 0) begin
            if (r < 12) return tab_stamp[$urandom_range(0, fill_count - 1)] + 1'b1;
            return tab_stamp[$urandom_range(0, fill_count - 1)] - 1'b1;
        end
        return $urandom;
    endfunction

    // sender idle length: mostly none, sometimes short, rarely long
    function automatic int sender_gap();
        int r;
        if (items_sent >= 120 && items_sent < 180) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one item and record its quote once the block takes it
    task automatic offer_update(input logic [DATA_W-1:0] stamp,
                                input logic [DATA_W-1:0] price,
                                input logic fixed, input t_quote want);
        t_quote pred;
        int     gap;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_stamp    = stamp;
        i_price_in = price;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = price_table_update(stamp, price);
        quote_q.push_back(fixed ? want : pred);
        items_sent++;
        gap = sender_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // receiver back-pressure, with one long hold-off to fill the block up
    always @(negedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (!hold_done && quotes_seen >= HOLD_AT) begin
            hold_done   = 1'b1;
            stall_left  = HOLD_CYCLES - 1;
            i_out_stall = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall = 1'b1;
        end else if (quotes_seen >= 250 && quotes_seen < 300) begin
            i_out_stall = 1'b0;
        end else if (r < 75) begin
            i_out_stall = 1'b0;
        end else if (r < 97) begin
            stall_left  = $urandom_range(0, 3);
            i_out_stall = 1'b1;
        end else begin
            stall_left  = $urandom_range(10, 80);
            i_out_stall = 1'b1;
        end
    end

    // compare each result item with the oldest pending quote
    always @(posedge i_clk) begin
        t_quote want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            quotes_seen++;
            if (quote_q.size() == 0) begin
                $error("result with no pending update");
                err_count++;
            end else begin
                want = quote_q.pop_front();
                if (o_latest_price !== want.latest) begin
                    $error("latest_price: expected %h, got %h", want.latest, o_latest_price);
                    err_count++;
                end
                if (o_max_price !== want.hi) begin
                    $error("max_price: expected %h, got %h", want.hi, o_max_price);
                    err_count++;
                end
                if (o_min_price !== want.lo) begin
                    $error("min_price: expected %h, got %h", want.lo, o_min_price);
                    err_count++;
                end
                if (o_dropped !== want.dropped) begin
                    $error("dropped: expected %b, got %b", want.dropped, o_dropped);
                    err_count++;
                end
            end
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("keyed_price_table_min_max_top verification failed");
        $finish;
    end

    // reset, directed table, random updates, drain
    initial begin
        logic [DATA_W-1:0] stamp;
        bit                pick_new;
        int                n;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_stamp      = '0;
        i_price_in   = '0;
        i_out_stall  = 1'b0;
        fill_count   = 0;
        newest_stamp = '0;
        newest_price = '0;
        err_count    = 0;
        items_sent   = 0;
        quotes_seen  = 0;
        stall_left   = 0;
        hold_done    = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (n = 0; n < N_DIRECTED; n++) begin
            offer_update(DIR_ROWS[n].stamp, DIR_ROWS[n].price,
                         DIR_ROWS[n].fixed, DIR_ROWS[n].want);
        end

        // fill the table with mostly new stamps, then hammer the full table
        // with corrections and new stamps that must be dropped
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (fill_count < TABLE_DEPTH) pick_new = $urandom_range(0, 99) < 60;
            else pick_new = $urandom_range(0, 99) < 40;
            if (pick_new) stamp = rand_new_stamp();
            else stamp = tab_stamp[$urandom_range(0, fill_count - 1)];
            offer_update(stamp, rand_price(), 1'b0, '0);
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (quote_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (quote_q.size() != 0) begin
            $error("%0d quotes never arrived", quote_q.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("keyed_price_table_min_max_top verification clean");
        end else begin
            $display("keyed_price_table_min_max_top verification failed");
        end
        $finish;
    end

endmodule
